// ===== sv/epv_pkg.sv =====
package epv_pkg;

	localparam int unsigned CH_W   = 8;
	localparam int unsigned RULE_W = 2;
	localparam int unsigned IDX_W  = 2;

	// config register indexes
	localparam logic [IDX_W-1:0] CFG_START_RULE   = 2'd0;
	localparam logic [IDX_W-1:0] CFG_END_RULE     = 2'd1;
	localparam logic [IDX_W-1:0] CFG_PATTERN_RULE = 2'd2;

	// rule codes (2-bit two's complement); anything else means no rule
	localparam logic [RULE_W-1:0] RULE_MUST     = 2'b01;
	localparam logic [RULE_W-1:0] RULE_MUST_NOT = 2'b11;

	// scanner phases
	localparam logic [2:0] PH_NORMAL = 3'd0;
	localparam logic [2:0] PH_ESC    = 3'd1;
	localparam logic [2:0] PH_OCT2   = 3'd2;
	localparam logic [2:0] PH_OCT3   = 3'd3;
	localparam logic [2:0] PH_FAIL   = 3'd4;

	localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CH_W-1:0] CH_DEL    = 8'h7F;
	localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CH_W-1:0] CH_THREE  = 8'h33;
	localparam logic [CH_W-1:0] CH_SEVEN  = 8'h37;

	typedef struct packed {
		logic [RULE_W-1:0] start_rule;
		logic [RULE_W-1:0] end_rule;
		logic [RULE_W-1:0] pattern_rule;
	} epv_rules_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [4:0] octal_prefix;
		logic       at_first_byte;
		logic       last_was_slash;
		logic       saw_pattern;
	} epv_state_t;

	localparam epv_state_t STATE_CLEAR = '{
		phase: PH_NORMAL, octal_prefix: 5'd0, at_first_byte: 1'b1,
		last_was_slash: 1'b0, saw_pattern: 1'b0
	};

	function automatic logic slash_ok(input logic [RULE_W-1:0] rule, input logic is_slash);
		logic r;
		case (rule)
			RULE_MUST:     r = is_slash;
			RULE_MUST_NOT: r = !is_slash;
			default:       r = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic is_wildcard(input logic [CH_W-1:0] c);
		return (c == 8'h24) || (c == 8'h2B) || (c == 8'h3F) || (c == 8'h2A) ||
		       (c == 8'h40) || (c == 8'h78) || (c == 8'h58) || (c == 8'h61) ||
		       (c == 8'h41) || (c == 8'h2D);
	endfunction

endpackage

// ===== sv/epv_step.sv =====
module epv_step import epv_pkg::*; (
	input  epv_state_t        cur,
	input  epv_rules_t        rules,
	input  logic [CH_W-1:0]   ch,
	output epv_state_t        nxt,
	output logic              ok
);

	logic       is_slash;
	logic       is_octal;
	logic [7:0] oct_val;
	logic [2:0] phase_in;

	assign is_slash = (ch == CH_SLASH);
	assign is_octal = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
	assign oct_val  = {cur.octal_prefix, ch[2:0]};

	// verdict for a terminating NUL
	always_comb begin
		if (cur.at_first_byte) begin
			ok = slash_ok(rules.start_rule, 1'b0) && slash_ok(rules.end_rule, 1'b0);
		end else begin
			ok = slash_ok(rules.end_rule, cur.last_was_slash);
		end
		if (cur.phase != PH_NORMAL) begin
			ok = 1'b0;
		end
		if ((rules.pattern_rule == RULE_MUST) && !cur.saw_pattern) begin
			ok = 1'b0;
		end
	end

	always_comb begin
		nxt = cur;
		phase_in = cur.phase;
		if (ch == CH_NUL) begin
			nxt = STATE_CLEAR;
		end else begin
			if (cur.at_first_byte && !slash_ok(rules.start_rule, is_slash)) begin
				phase_in = PH_FAIL;
			end
			nxt.at_first_byte  = 1'b0;
			nxt.last_was_slash = is_slash;
			nxt.phase          = phase_in;
			case (phase_in)
				PH_NORMAL: begin
					if (ch == CH_BSLASH) begin
						nxt.phase = PH_ESC;
					end else if ((ch <= CH_SPACE) || (ch >= CH_DEL)) begin
						nxt.phase = PH_FAIL;
					end
				end
				PH_ESC: begin
					if (ch == CH_BSLASH) begin
						nxt.phase = PH_NORMAL;
					end else if (is_wildcard(ch)) begin
						if (rules.pattern_rule == RULE_MUST_NOT) begin
							nxt.phase = PH_FAIL;
						end else begin
							nxt.saw_pattern = 1'b1;
							nxt.phase       = PH_NORMAL;
						end
					end else if ((ch >= CH_ZERO) && (ch <= CH_THREE)) begin
						nxt.octal_prefix = {ch[1:0], 3'd0};
						nxt.phase        = PH_OCT2;
					end else begin
						nxt.phase = PH_FAIL;
					end
				end
				PH_OCT2: begin
					if (is_octal) begin
						nxt.octal_prefix = {cur.octal_prefix[4:3], ch[2:0]};
						nxt.phase        = PH_OCT3;
					end else begin
						nxt.phase = PH_FAIL;
					end
				end
				PH_OCT3: begin
					if (is_octal && (oct_val != 8'd0) &&
					    ((oct_val <= CH_SPACE) || (oct_val >= CH_DEL))) begin
						nxt.phase = PH_NORMAL;
					end else begin
						nxt.phase = PH_FAIL;
					end
					nxt.octal_prefix = 5'd0;
				end
				default: begin
					nxt.phase = PH_FAIL;
				end
			endcase
		end
	end

endmodule

// ===== sv/escaped_path_validator_core.sv =====
// Escaped path name checker. Bytes of a name enter on the in_* channel, one
// beat per byte, the name closed by a NUL byte; for each NUL a single beat
// leaves on the out_* channel carrying path_ok (1 accept, 0 reject). Plain
// bytes must be printable non-space ASCII; a backslash must introduce "\\",
// a wildcard character or a three-digit octal escape for a nonzero value
// not allowed plain. The three rule registers (0 start, 1 end, 2 pattern;
// 2-bit signed, 1 = required, -1 = forbidden, otherwise no rule) are written
// through cfg_* and should only be changed between names while nothing is
// in flight. The block takes one byte per clock unless in_stall is raised:
// a byte in the input register is decoded against the scanner state by one
// step of logic; as it leaves, the state updates and a NUL's verdict enters
// the result register. in_stall rises only when a NUL sits in the input
// register while a previous verdict is still stalled at the output.
module escaped_path_validator_core import epv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// byte channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CH_W-1:0]   ch,
	// verdict channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              path_ok,
	// rule registers
	input  logic              cfg_wr_en,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [RULE_W-1:0] cfg_data
);

	logic [CH_W-1:0] ch_s1;
	logic            valid_s1;
	epv_rules_t      rules_q;
	epv_state_t      state_q;
	epv_state_t      state_nxt;
	logic            verdict;
	logic            is_nul_s1;
	logic            advance;
	logic            out_valid_q;
	logic            path_ok_q;

	assign is_nul_s1 = (ch_s1 == CH_NUL);
	// a non-NUL byte always drains; a NUL needs room in the result register
	assign advance   = valid_s1 && (!is_nul_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign path_ok   = path_ok_q;

	epv_step u_step (
		.cur   (state_q),
		.rules (rules_q),
		.ch    (ch_s1),
		.nxt   (state_nxt),
		.ok    (verdict)
	);

	// rule registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_START_RULE:   rules_q.start_rule   <= cfg_data;
				CFG_END_RULE:     rules_q.end_rule     <= cfg_data;
				CFG_PATTERN_RULE: rules_q.pattern_rule <= cfg_data;
				default:          rules_q              <= rules_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1 <= ch;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_nul_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_nul_s1) begin
			path_ok_q <= verdict;
		end
	end

endmodule
